FILE: sv/solk_pkg.sv
// Shared types, sizing constants and key/saturation helpers for the
// spin-orbital integral lookup core. Has no dependencies; used by all but solk_ram.
package solk_pkg;

    // Sizing
    localparam int MAX_SPATIAL = 8;
    localparam int TABLE_DEPTH = 2048;
    localparam int VALUE_BITS  = 32;

    // Fixed field widths
    localparam int DATA_W   = 32;
    localparam int KEY_IN_W = 11;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 4;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // Largest 1-based spatial orbital that a query can reach
    localparam int IDX_SPATIAL = (1 << IDX_W) / 2;
    localparam int SPATIAL_MAX = (MAX_SPATIAL < IDX_SPATIAL) ? MAX_SPATIAL : IDX_SPATIAL;
    localparam int SPATIAL_W   = $clog2(SPATIAL_MAX + 1);
    localparam int PAIR_MAX    = SPATIAL_MAX * (SPATIAL_MAX + 1) / 2 + SPATIAL_MAX;
    localparam int PAIR_W      = $clog2(PAIR_MAX + 1);
    localparam int KEY_MAX     = PAIR_MAX * (PAIR_MAX + 1) / 2 + PAIR_MAX;
    localparam int KEY_W       = $clog2(KEY_MAX + 1);
    localparam int LIMIT_W     = $clog2(2 * MAX_SPATIAL + 1);

    // Saturation range
    localparam int SAT_BITS = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
    localparam logic signed [DATA_W:0] SAT_HI =
        (DATA_W + 1)'((64'd1 << (SAT_BITS - 1)) - 64'd1);
    localparam logic signed [DATA_W:0] SAT_LO = ~SAT_HI;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SPATIAL = '0;
    localparam logic [CFG_W-1:0] CFG_SPATIAL_RESET = CFG_W'(8);

    typedef struct packed {
        logic                     operation;
        logic [KEY_IN_W-1:0]      entry_key;
        logic signed [DATA_W-1:0] entry_value;
        logic [IDX_W-1:0]         spin_p;
        logic [IDX_W-1:0]         spin_q;
        logic [IDX_W-1:0]         spin_r;
        logic [IDX_W-1:0]         spin_s;
    } solk_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] integral;
        logic                     index_error;
    } solk_out_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } solk_key_info_t;

    // 1-based spatial orbital of a 0-based spin orbital
    function automatic logic [SPATIAL_W-1:0] spatial_of(logic [IDX_W-1:0] idx);
        return SPATIAL_W'({1'b0, idx[IDX_W-1:1]} + IDX_W'(1));
    endfunction

    // Triangular pair key of two spatial orbitals
    function automatic logic [PAIR_W-1:0] pair_key(logic [SPATIAL_W-1:0] a,
                                                   logic [SPATIAL_W-1:0] b);
        logic [SPATIAL_W-1:0] hi;
        logic [SPATIAL_W-1:0] lo;
        logic [2*SPATIAL_W:0] hx;
        logic [2*SPATIAL_W:0] prod;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        hx   = (2 * SPATIAL_W + 1)'(hi);
        prod = hx * (hx + 1'b1);
        return PAIR_W'((prod >> 1) + (2 * SPATIAL_W + 1)'(lo));
    endfunction

    // Triangular compound key of two pair keys
    function automatic logic [KEY_W-1:0] quad_key(logic [PAIR_W-1:0] a,
                                                  logic [PAIR_W-1:0] b);
        logic [PAIR_W-1:0] hi;
        logic [PAIR_W-1:0] lo;
        logic [2*PAIR_W:0] hx;
        logic [2*PAIR_W:0] prod;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        hx   = (2 * PAIR_W + 1)'(hi);
        prod = hx * (hx + 1'b1);
        return KEY_W'((prod >> 1) + (2 * PAIR_W + 1)'(lo));
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_value(logic signed [DATA_W:0] v);
        if (v > SAT_HI) return SAT_HI[DATA_W-1:0];
        if (v < SAT_LO) return SAT_LO[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

endpackage

FILE: sv/solk_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Standalone; instanced by the lookup core for the integral table.
module solk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

FILE: sv/solk_key_unit.sv
// Compound-key unit: folds two pair keys into a table address and range flag.
// Depends on solk_pkg.
module solk_key_unit (
    input  logic [solk_pkg::PAIR_W-1:0] pair_a,
    input  logic [solk_pkg::PAIR_W-1:0] pair_b,
    output solk_pkg::solk_key_info_t    key_info
);

    logic [solk_pkg::KEY_W-1:0] key;
    logic [31:0]                key_x;

    always_comb begin
        key           = solk_pkg::quad_key(pair_a, pair_b);
        key_x         = 32'(key);
        // keys past the table read as zero
        key_info.hit  = key_x < 32'(solk_pkg::TABLE_DEPTH);
        key_info.addr = key_x[solk_pkg::ADDR_W-1:0];
    end

endmodule

FILE: sv/solk_apb_regs.sv
// APB configuration register block: holds the spatial orbital count.
// Depends on solk_pkg.
module solk_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [solk_pkg::PADDR_W-1:0]  paddr,
    input  logic [solk_pkg::PDATA_W-1:0]  pwdata,
    output logic [solk_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [solk_pkg::CFG_W-1:0]    spatial_orbitals
);

    logic [solk_pkg::REG_IDX_W-1:0] reg_idx;
    logic [solk_pkg::CFG_W-1:0]     spatial_reg;
    logic [solk_pkg::CFG_W-1:0]     spatial_next;

    assign reg_idx          = paddr[solk_pkg::PADDR_W-1:2];
    assign pready           = 1'b1;
    assign spatial_orbitals = spatial_reg;

    always_comb begin
        spatial_next = spatial_reg;
        if (psel && penable && pwrite && reg_idx == solk_pkg::REG_SPATIAL) begin
            spatial_next = pwdata[solk_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        if (reg_idx == solk_pkg::REG_SPATIAL) begin
            prdata = solk_pkg::PDATA_W'(spatial_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spatial_reg <= solk_pkg::CFG_SPATIAL_RESET;
        end else begin
            spatial_reg <= spatial_next;
        end
    end

endmodule

FILE: sv/spin_orbital_integral_lookup_core.sv
// Top level of the antisymmetrized two-electron integral lookup.
// Depends on solk_pkg, solk_ram, solk_key_unit and solk_apb_regs.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    solk_in_t  (load or query)
//   m_        out        m_valid/m_ready    solk_out_t (one per query)
//   apb       in/out     psel/penable       spatial_orbitals at byte 0
//
// A load is written into the table at its accept edge. A query registers
// its pair keys at accept, reads the table in ST_KEY and ST_RD2 on the
// single RAM port, then subtracts and saturates into the output register
// in ST_RES; a flagged query skips the two reads.
// After reset a clearing pass writes zero to all 2048 entries, one per
// cycle, with s_ready low; configuration writes are taken meanwhile.
// The output register holds a result while m_ready is low; a new transaction
// is still accepted and its result waits in the last step.
module spin_orbital_integral_lookup_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [solk_pkg::PADDR_W-1:0]  paddr,
    input  logic [solk_pkg::PDATA_W-1:0]  pwdata,
    output logic [solk_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  solk_pkg::solk_in_t            s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output solk_pkg::solk_out_t           m_payload
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_RD2,
        ST_RES
    } state_t;

    state_t state_reg;

    logic [solk_pkg::CFG_W-1:0]   spatial_orbitals;
    logic [solk_pkg::ADDR_W-1:0]  clr_cnt_reg;
    logic                         clr_active_reg;

    logic [solk_pkg::PAIR_W-1:0]  pair_pr_reg;
    logic [solk_pkg::PAIR_W-1:0]  pair_qs_reg;
    logic [solk_pkg::PAIR_W-1:0]  pair_ps_reg;
    logic [solk_pkg::PAIR_W-1:0]  pair_qr_reg;
    logic                         dir_en_reg;
    logic                         exc_en_reg;
    logic                         err_reg;
    logic                         dir_on_reg;
    logic                         exc_on_reg;
    logic signed [solk_pkg::DATA_W-1:0] dir_val_reg;

    logic                         m_valid_reg;
    solk_pkg::solk_out_t          out_reg;

    logic                         accept;
    logic [solk_pkg::LIMIT_W-1:0] limit;
    logic                         idx_err;
    logic [solk_pkg::SPATIAL_W-1:0] sp_p;
    logic [solk_pkg::SPATIAL_W-1:0] sp_q;
    logic [solk_pkg::SPATIAL_W-1:0] sp_r;
    logic [solk_pkg::SPATIAL_W-1:0] sp_s;
    logic [31:0]                  load_key_x;
    logic                         load_hit;

    logic [solk_pkg::PAIR_W-1:0]  ku_pair_a;
    logic [solk_pkg::PAIR_W-1:0]  ku_pair_b;
    solk_pkg::solk_key_info_t     key_info;

    logic                         ram_en;
    logic                         ram_we;
    logic [solk_pkg::ADDR_W-1:0]  ram_addr;
    logic [solk_pkg::DATA_W-1:0]  ram_wdata;
    logic [solk_pkg::DATA_W-1:0]  ram_rdata;

    logic signed [solk_pkg::DATA_W-1:0] exc_val;
    logic signed [solk_pkg::DATA_W:0]   diff;

    solk_apb_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .spatial_orbitals (spatial_orbitals)
    );

    solk_key_unit u_key (
        .pair_a   (ku_pair_a),
        .pair_b   (ku_pair_b),
        .key_info (key_info)
    );

    solk_ram #(
        .WIDTH (solk_pkg::DATA_W),
        .DEPTH (solk_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !clr_active_reg;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // Query decode at the accept edge
    always_comb begin
        if (32'(spatial_orbitals) > 32'(solk_pkg::MAX_SPATIAL)) begin
            limit = solk_pkg::LIMIT_W'(2 * solk_pkg::MAX_SPATIAL);
        end else begin
            limit = solk_pkg::LIMIT_W'({spatial_orbitals, 1'b0});
        end
        idx_err = (32'(s_payload.spin_p) >= 32'(limit))
               || (32'(s_payload.spin_q) >= 32'(limit))
               || (32'(s_payload.spin_r) >= 32'(limit))
               || (32'(s_payload.spin_s) >= 32'(limit));
        sp_p = solk_pkg::spatial_of(s_payload.spin_p);
        sp_q = solk_pkg::spatial_of(s_payload.spin_q);
        sp_r = solk_pkg::spatial_of(s_payload.spin_r);
        sp_s = solk_pkg::spatial_of(s_payload.spin_s);
        load_key_x = 32'(s_payload.entry_key);
        load_hit   = load_key_x < 32'(solk_pkg::TABLE_DEPTH);
    end

    // Share the key unit: direct pairs first, exchange pairs on the second read
    always_comb begin
        if (state_reg == ST_RD2) begin
            ku_pair_a = pair_ps_reg;
            ku_pair_b = pair_qr_reg;
        end else begin
            ku_pair_a = pair_pr_reg;
            ku_pair_b = pair_qs_reg;
        end
    end

    // Single table port: clearing pass, then loads, then query reads
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = key_info.addr;
        ram_wdata = solk_pkg::sat_value({s_payload.entry_value[solk_pkg::DATA_W-1],
                                         s_payload.entry_value});
        if (clr_active_reg) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end else if (accept && s_payload.operation == solk_pkg::OP_LOAD) begin
            ram_en   = load_hit;
            ram_we   = 1'b1;
            ram_addr = load_key_x[solk_pkg::ADDR_W-1:0];
        end else if (state_reg == ST_KEY || state_reg == ST_RD2) begin
            ram_en = 1'b1;
        end
    end

    always_comb begin
        exc_val = exc_on_reg ? ram_rdata : '0;
        diff    = {dir_val_reg[solk_pkg::DATA_W-1], dir_val_reg}
                - {exc_val[solk_pkg::DATA_W-1], exc_val};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == solk_pkg::ADDR_W'(solk_pkg::TABLE_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end

            // the final step refills the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_RES) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_payload.operation == solk_pkg::OP_QUERY) begin
                        pair_pr_reg <= solk_pkg::pair_key(sp_p, sp_r);
                        pair_qs_reg <= solk_pkg::pair_key(sp_q, sp_s);
                        pair_ps_reg <= solk_pkg::pair_key(sp_p, sp_s);
                        pair_qr_reg <= solk_pkg::pair_key(sp_q, sp_r);
                        // a term counts only where both pairs share spin
                        dir_en_reg  <= (s_payload.spin_p[0] == s_payload.spin_r[0])
                                    && (s_payload.spin_q[0] == s_payload.spin_s[0]);
                        exc_en_reg  <= (s_payload.spin_p[0] == s_payload.spin_s[0])
                                    && (s_payload.spin_q[0] == s_payload.spin_r[0]);
                        err_reg     <= idx_err;
                        state_reg   <= idx_err ? ST_RES : ST_KEY;
                    end
                end
                ST_KEY: begin
                    dir_on_reg <= dir_en_reg && key_info.hit;
                    state_reg  <= ST_RD2;
                end
                ST_RD2: begin
                    dir_val_reg <= dir_on_reg ? ram_rdata : '0;
                    exc_on_reg  <= exc_en_reg && key_info.hit;
                    state_reg   <= ST_RES;
                end
                ST_RES: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        out_reg.integral    <= err_reg ? '0 : solk_pkg::sat_value(diff);
                        out_reg.index_error <= err_reg;
                        m_valid_reg         <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_query_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_payload.operation == solk_pkg::OP_QUERY)
        |=> (state_reg == ST_KEY || state_reg == ST_RES))
        else $error("query transaction did not start its lookup");

    a_load_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_payload.operation == solk_pkg::OP_LOAD) |=> state_reg == ST_IDLE)
        else $error("load transaction left the sequencer busy");

    a_result_from_res: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RES)
        else $error("result appeared outside the final step");

    a_clear_full_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_active_reg)
        |-> $past(clr_cnt_reg) == solk_pkg::ADDR_W'(solk_pkg::TABLE_DEPTH - 1))
        else $error("clearing pass ended early");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.index_error) |-> out_reg.integral == '0)
        else $error("flagged result carries a nonzero integral");

endmodule

FILE: tb/tb.sv
// Self-checking bench for spin_orbital_integral_lookup_core: loads and queries on the
// valid/ready channels, orbital count over APB, results checked against an in-bench model.
// Depends on solk_pkg and the core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import solk_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] FIX_ONE   = 32'sh08000000;
    localparam logic [PADDR_W-1:0] SPATIAL_ADDR = PADDR_W'({REG_SPATIAL, 2'b00});

    typedef enum int unsigned {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_e;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    solk_in_t            s_payload = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    solk_out_t           m_payload;

    // model state
    logic signed [DATA_W-1:0] integral_store [TABLE_DEPTH];
    logic [CFG_W-1:0]         cfg_spatial;
    solk_out_t                pending_results [$];
    solk_out_t                head_result;

    int unsigned mismatches  = 0;
    bit          idling_on   = 1'b1;
    int unsigned burst_left  = 0;
    bit          holdoff_tgl = 1'b0;

    spin_orbital_integral_lookup_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- model

    function automatic int unsigned tri_key(input int unsigned a, input int unsigned b);
        int unsigned hi;
        int unsigned lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return hi * (hi + 1) / 2 + lo;
    endfunction

    function automatic int unsigned direct_key_of(input logic [IDX_W-1:0] p, q, r, s);
        return tri_key(tri_key(p / 2 + 1, r / 2 + 1), tri_key(q / 2 + 1, s / 2 + 1));
    endfunction

    function automatic int unsigned exchange_key_of(input logic [IDX_W-1:0] p, q, r, s);
        return tri_key(tri_key(p / 2 + 1, s / 2 + 1), tri_key(q / 2 + 1, r / 2 + 1));
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_value(input longint v);
        int unsigned bits;
        longint      top;
        bits = (VALUE_BITS < 32) ? VALUE_BITS : 32;
        top  = (longint'(1) <<< (bits - 1)) - 1;
        if (v > top) return DATA_W'(top);
        if (v < -top - 1) return DATA_W'(-top - 1);
        return DATA_W'(v);
    endfunction

    function automatic longint read_entry(input int unsigned key);
        if (key >= TABLE_DEPTH) return 0;
        return longint'(integral_store[key]);
    endfunction

    function automatic int unsigned spin_limit();
        return 2 * ((cfg_spatial > MAX_SPATIAL) ? MAX_SPATIAL : cfg_spatial);
    endfunction

    // Apply one accepted transaction; return 1 with the expected result for a query.
    function automatic bit lookup_predict(input solk_in_t it, output solk_out_t res);
        int unsigned lim;
        longint      direct;
        longint      exchange;
        res      = '0;
        direct   = 0;
        exchange = 0;
        if (it.operation == OP_LOAD) begin
            if (it.entry_key < TABLE_DEPTH)
                integral_store[it.entry_key] = clamp_value(longint'(it.entry_value));
            return 1'b0;
        end
        lim = spin_limit();
        if (it.spin_p >= lim || it.spin_q >= lim || it.spin_r >= lim || it.spin_s >= lim) begin
            res.index_error = 1'b1;
            return 1'b1;
        end
        if (it.spin_p[0] == it.spin_r[0] && it.spin_q[0] == it.spin_s[0])
            direct = read_entry(direct_key_of(it.spin_p, it.spin_q, it.spin_r, it.spin_s));
        if (it.spin_p[0] == it.spin_s[0] && it.spin_q[0] == it.spin_r[0])
            exchange = read_entry(exchange_key_of(it.spin_p, it.spin_q, it.spin_r, it.spin_s));
        res.integral = clamp_value(direct - exchange);
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic solk_in_t make_load(input logic [KEY_IN_W-1:0] key,
                                           input logic signed [DATA_W-1:0] value);
        solk_in_t it;
        it.operation   = OP_LOAD;
        it.entry_key   = key;
        it.entry_value = value;
        it.spin_p      = IDX_W'($urandom);
        it.spin_q      = IDX_W'($urandom);
        it.spin_r      = IDX_W'($urandom);
        it.spin_s      = IDX_W'($urandom);
        return it;
    endfunction

    function automatic solk_in_t make_query(input logic [IDX_W-1:0] p, q, r, s);
        solk_in_t it;
        it.operation   = OP_QUERY;
        it.entry_key   = KEY_IN_W'($urandom);
        it.entry_value = DATA_W'($urandom);
        it.spin_p      = p;
        it.spin_q      = q;
        it.spin_r      = r;
        it.spin_s      = s;
        return it;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return DATA_W'($urandom_range(0, 15)) << 27;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Mostly in range; now and then any index so the error flag shows up.
    function automatic logic [IDX_W-1:0] random_spin(input int unsigned lim);
        if (lim == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 15));
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input solk_in_t it);
        solk_out_t   res;
        int unsigned gap;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (lookup_predict(it, res)) pending_results.push_back(res);
        if (idling_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 7);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Drop valid, wait for every expected result, then let any load settle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input bit is_write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_orbital_register();
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b0, SPATIAL_ADDR, '0, rdata);
        if (rdata !== PDATA_W'(cfg_spatial)) begin
            mismatches++;
            $display("%0t: spatial_orbitals readback expected %0d got %0d",
                     $time, cfg_spatial, rdata);
        end
    endtask

    task automatic set_orbital_count(input logic [CFG_W-1:0] count);
        logic [PDATA_W-1:0] rdata;
        drain_results();
        apb_access(1'b1, SPATIAL_ADDR, PDATA_W'(count), rdata);
        cfg_spatial = count;
        check_orbital_register();
    endtask

    // ---------------------------------------------------------------- result sink

    initial begin : result_sink
        sink_mode_e  mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          seen_tgl;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        seen_tgl  = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_tgl != seen_tgl) begin
                seen_tgl  = holdoff_tgl;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ((mode_left % 8) < 5);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result expected none got integral %0d error %0b",
                         $time, m_payload.integral, m_payload.index_error);
            end else begin
                head_result = pending_results.pop_front();
                if (m_payload.integral !== head_result.integral) begin
                    mismatches++;
                    $display("%0t: integral expected %0d got %0d",
                             $time, head_result.integral, m_payload.integral);
                end
                if (m_payload.index_error !== head_result.index_error) begin
                    mismatches++;
                    $display("%0t: index_error expected %0b got %0b",
                             $time, head_result.index_error, m_payload.index_error);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed_lookups();
        logic [KEY_IN_W-1:0] dk;
        logic [KEY_IN_W-1:0] xk;
        logic [KEY_IN_W-1:0] top_key;
        dk      = KEY_IN_W'(direct_key_of(0, 2, 4, 6));
        xk      = KEY_IN_W'(exchange_key_of(0, 2, 4, 6));
        top_key = KEY_IN_W'(direct_key_of(15, 15, 15, 15));
        // nothing loaded yet: every key reads zero
        send_item(make_query(0, 0, 0, 0));
        send_item(make_query(0, 2, 4, 6));
        // difference overflows both ways
        send_item(make_load(dk, VALUE_MAX));
        send_item(make_load(xk, VALUE_MIN));
        send_item(make_query(0, 2, 4, 6));
        send_item(make_load(dk, VALUE_MIN));
        send_item(make_load(xk, VALUE_MAX));
        send_item(make_query(0, 2, 4, 6));
        send_item(make_load(dk, FIX_ONE * 5));
        send_item(make_load(xk, FIX_ONE * 3));
        send_item(make_query(0, 2, 4, 6));
        // spin mismatch: both terms off, direct only, exchange only
        send_item(make_query(1, 2, 4, 6));
        send_item(make_query(0, 3, 4, 7));
        send_item(make_query(0, 3, 5, 6));
        // highest orbital index
        send_item(make_load(top_key, -FIX_ONE * 7));
        send_item(make_query(15, 15, 15, 15));
        send_item(make_query(15, 14, 15, 14));
        // table corners, reachable or not
        send_item(make_load('0, -32'sd1));
        send_item(make_load('1, VALUE_MAX));
        send_item(make_query(1, 1, 1, 1));
    endtask

    task automatic test_orbital_count_limits();
        set_orbital_count(CFG_W'(0));
        send_item(make_query(0, 0, 0, 0));
        send_item(make_query(15, 15, 15, 15));
        set_orbital_count(CFG_W'(1));
        send_item(make_query(0, 1, 0, 1));
        send_item(make_query(2, 0, 0, 0));
        send_item(make_query(0, 2, 0, 0));
        send_item(make_query(0, 0, 2, 0));
        send_item(make_query(0, 0, 0, 2));
        set_orbital_count(CFG_W'(15));
        send_item(make_query(15, 14, 15, 14));
        send_item(make_query(14, 15, 14, 15));
        set_orbital_count(CFG_W'(4));
        send_item(make_query(8, 0, 0, 0));
        send_item(make_query(7, 7, 7, 7));
        send_item(make_query(0, 0, 0, 8));
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] count, input int unsigned n_items);
        int unsigned       sent;
        int unsigned       lim;
        int unsigned       pick;
        logic [IDX_W-1:0]  p, q, r, s;
        set_orbital_count(count);
        lim  = spin_limit();
        sent = 0;
        while (sent < n_items) begin
            p = random_spin(lim);
            q = random_spin(lim);
            r = random_spin(lim);
            s = random_spin(lim);
            // bias the spins so that direct, exchange or both terms are live
            case ($urandom_range(0, 3))
                0: begin r[0] = p[0]; s[0] = q[0]; end
                1: begin s[0] = p[0]; r[0] = q[0]; end
                2: begin q[0] = p[0]; r[0] = p[0]; s[0] = p[0]; end
                default: ;
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                send_item(make_load(KEY_IN_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                    random_value()));
                sent += 1;
            end else if (pick < 5) begin
                send_item(make_load(KEY_IN_W'(direct_key_of(p, q, r, s)), random_value()));
                send_item(make_load(KEY_IN_W'(exchange_key_of(p, q, r, s)), random_value()));
                send_item(make_query(p, q, r, s));
                sent += 3;
            end else begin
                send_item(make_query(p, q, r, s));
                sent += 1;
            end
        end
    endtask

    // Hold the sink off while queries keep coming, so the core backs up.
    task automatic test_backpressure_fill();
        int unsigned i;
        int unsigned lim;
        lim       = spin_limit();
        idling_on = 1'b0;
        holdoff_tgl = ~holdoff_tgl;
        for (i = 0; i < 80; i++)
            send_item(make_query(random_spin(lim), random_spin(lim),
                                 random_spin(lim), random_spin(lim)));
        idling_on = 1'b1;
    endtask

    initial begin : test_sequence
        int unsigned i;
        for (i = 0; i < TABLE_DEPTH; i++) integral_store[i] = '0;
        cfg_spatial = CFG_SPATIAL_RESET;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        check_orbital_register();
        test_directed_lookups();
        test_orbital_count_limits();
        test_random_traffic(CFG_W'(8), 300);
        test_random_traffic(CFG_W'(3), 200);
        idling_on = 1'b0;
        test_random_traffic(CFG_W'(15), 250);
        idling_on = 1'b1;
        test_random_traffic(CFG_W'(1), 150);
        test_random_traffic(CFG_W'(0), 60);
        test_random_traffic(CFG_W'(6), 250);
        test_backpressure_fill();
        drain_results();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
